@@ rtl/core/complex_arithmetic_unit_core_assert.svh @@
// Assertion macros for the complex arithmetic unit
`ifndef COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
`define COMPLEX_ARITHMETIC_UNIT_CORE_ASSERT_SVH
// same-cycle implication
`define CAU_ASSERT_HOLDS(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error(msg);
// next-cycle implication
`define CAU_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error(msg);
`endif

@@ rtl/core/cau_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_pkg
// Types, constants and helpers shared by the complex arithmetic unit.
// ----------------------------------------------------------------------------
package cau_pkg;

   localparam int FIELD_BITS  = 32;
   localparam int WORD_BITS   = 32;
   localparam int FRAC_BITS   = 16;
   localparam int PROD_BITS   = 2 * WORD_BITS;
   localparam int SUM_BITS    = PROD_BITS + 1;
   localparam int SQREM_BITS  = WORD_BITS + 2;
   localparam int SHIFT_BITS  = WORD_BITS - FRAC_BITS;
   localparam int ITER_STAGES = WORD_BITS;

   localparam logic [3:0] KIND_ADD  = 4'd0;
   localparam logic [3:0] KIND_SUB  = 4'd1;
   localparam logic [3:0] KIND_MUL  = 4'd2;
   localparam logic [3:0] KIND_DIV  = 4'd3;
   localparam logic [3:0] KIND_NEG  = 4'd4;
   localparam logic [3:0] KIND_CONJ = 4'd5;
   localparam logic [3:0] KIND_INV  = 4'd6;
   localparam logic [3:0] KIND_EQ   = 4'd7;
   localparam logic [3:0] KIND_LT   = 4'd8;
   localparam logic [3:0] KIND_GT   = 4'd9;
   localparam logic [3:0] KIND_MAG  = 4'd10;

   localparam logic [1:0] STATUS_OK        = 2'd0;
   localparam logic [1:0] STATUS_DIV_ZERO  = 2'd1;
   localparam logic [1:0] STATUS_SATURATED = 2'd2;

   typedef logic signed [WORD_BITS-1:0] word_type;

   localparam word_type WORD_MAX = {1'b0, {(WORD_BITS-1){1'b1}}};
   localparam word_type WORD_MIN = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam logic [WORD_BITS-1:0] WORD_HALF = {1'b1, {(WORD_BITS-1){1'b0}}};
   localparam word_type FIX_ONE  = word_type'(1) << FRAC_BITS;

   typedef struct packed {
      logic [3:0]                   kind;
      logic signed [FIELD_BITS-1:0] a_real;
      logic signed [FIELD_BITS-1:0] a_imag;
      logic signed [FIELD_BITS-1:0] b_real;
      logic signed [FIELD_BITS-1:0] b_imag;
   } req_type;

   typedef struct packed {
      logic signed [FIELD_BITS-1:0] result_real;
      logic signed [FIELD_BITS-1:0] result_imag;
      logic                         compare_true;
      logic [1:0]                   status;
   } rsp_type;

   typedef struct packed {
      logic     sat;
      word_type value;
   } sat_type;

   // result already settled before the iterative stages
   typedef struct packed {
      word_type re;
      word_type im;
      logic     cmp;
      logic     sat;
   } fix_type;

   typedef struct packed {
      logic                   neg;
      logic                   ovf;
      logic [PROD_BITS-1:0]   rem;
      logic [WORD_BITS-1:0]   num;
      logic [WORD_BITS-1:0]   q;
   } div_lane_type;

   typedef struct packed {
      logic [3:0]             kind;
      fix_type                fix;
      logic                   dz;
      logic [PROD_BITS-1:0]   den;
      div_lane_type           lane_r;
      div_lane_type           lane_i;
      logic [PROD_BITS-1:0]   sq_x;
      logic [SQREM_BITS-1:0]  sq_rem;
      logic [WORD_BITS-1:0]   sq_root;
   } iter_type;

   function automatic sat_type sat_sum(input logic signed [SUM_BITS-1:0] v);
      word_type lo;
      sat_type  r;
      lo = v[WORD_BITS-1:0];
      if (SUM_BITS'(lo) == v) begin
         r.sat   = 1'b0;
         r.value = lo;
      end else begin
         r.sat   = 1'b1;
         r.value = v[SUM_BITS-1] ? WORD_MIN : WORD_MAX;
      end
      return r;
   endfunction

endpackage

@@ rtl/core/cau_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_front
// Operand decode, products, sums and divide / root setup (four stages).
// ----------------------------------------------------------------------------
module cau_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::req_type  in_data,
   output logic              out_valid,
   output cau_pkg::iter_type out_data
);
   import cau_pkg::*;

   typedef struct packed {
      logic [3:0] kind;
      fix_type    fix;
      word_type   x;
      word_type   y;
      word_type   u;
      word_type   v;
   } s1_type;

   typedef struct packed {
      logic [3:0]                  kind;
      fix_type                     fix;
      logic signed [PROD_BITS-1:0] xu;
      logic signed [PROD_BITS-1:0] yv;
      logic signed [PROD_BITS-1:0] xv;
      logic signed [PROD_BITS-1:0] yu;
      logic signed [PROD_BITS-1:0] uu;
      logic signed [PROD_BITS-1:0] vv;
   } s2_type;

   typedef struct packed {
      logic [3:0]                 kind;
      fix_type                    fix;
      logic signed [SUM_BITS-1:0] p;
      logic signed [SUM_BITS-1:0] q;
      logic [PROD_BITS-1:0]       den;
   } s3_type;

   word_type a, b, c, d;
   sat_type  sr, si, mul_re, mul_im;
   s1_type   s1_in, s1_ff;
   s2_type   s2_in, s2_ff;
   s3_type   s3_in, s3_ff;
   iter_type s4_in, s4_ff;
   logic     v1_ff, v2_ff, v3_ff, v4_ff;

   function automatic logic signed [SUM_BITS-1:0] sxw(input word_type w);
      return SUM_BITS'(w);
   endfunction

   function automatic logic signed [SUM_BITS-1:0] sxp(input logic signed [PROD_BITS-1:0] w);
      return SUM_BITS'(w);
   endfunction

   function automatic div_lane_type lane_init(input logic signed [SUM_BITS-1:0] n,
                                              input logic [PROD_BITS-1:0] den);
      logic [PROD_BITS-1:0] mag;
      div_lane_type         l;
      mag   = n[SUM_BITS-1] ? PROD_BITS'(-n) : PROD_BITS'(n);
      l.neg = n[SUM_BITS-1];
      l.rem = mag >> SHIFT_BITS;
      l.ovf = (mag >> SHIFT_BITS) >= den;
      l.num = {mag[SHIFT_BITS-1:0], {FRAC_BITS{1'b0}}};
      l.q   = '0;
      return l;
   endfunction

   assign a = in_data.a_real[WORD_BITS-1:0];
   assign b = in_data.a_imag[WORD_BITS-1:0];
   assign c = in_data.b_real[WORD_BITS-1:0];
   assign d = in_data.b_imag[WORD_BITS-1:0];

   // stage 1: short ops finish here, operand mux for the long ones
   always_comb begin
      sr = '{sat: 1'b0, value: '0};
      si = '{sat: 1'b0, value: '0};
      s1_in.kind    = in_data.kind;
      s1_in.fix.cmp = 1'b0;
      case (in_data.kind)
         KIND_ADD: begin
            sr = sat_sum(sxw(a) + sxw(c));
            si = sat_sum(sxw(b) + sxw(d));
         end
         KIND_SUB: begin
            sr = sat_sum(sxw(a) - sxw(c));
            si = sat_sum(sxw(b) - sxw(d));
         end
         KIND_NEG: begin
            sr = sat_sum(-sxw(a));
            si = sat_sum(-sxw(b));
         end
         KIND_CONJ: begin
            sr = '{sat: 1'b0, value: a};
            si = sat_sum(-sxw(b));
         end
         KIND_EQ: s1_in.fix.cmp = (a == c) && (b == d);
         KIND_LT: s1_in.fix.cmp = (a < c) && (b < d);
         KIND_GT: s1_in.fix.cmp = (a > c) && (b > d);
         default: s1_in.fix.cmp = 1'b0;
      endcase
      s1_in.fix.re  = sr.value;
      s1_in.fix.im  = si.value;
      s1_in.fix.sat = sr.sat | si.sat;
      case (in_data.kind)
         KIND_INV: begin
            s1_in.x = FIX_ONE;
            s1_in.y = '0;
            s1_in.u = a;
            s1_in.v = b;
         end
         KIND_MAG: begin
            s1_in.x = '0;
            s1_in.y = '0;
            s1_in.u = a;
            s1_in.v = b;
         end
         default: begin
            s1_in.x = a;
            s1_in.y = b;
            s1_in.u = c;
            s1_in.v = d;
         end
      endcase
   end

   // stage 2: six parallel products
   always_comb begin
      s2_in.kind = s1_ff.kind;
      s2_in.fix  = s1_ff.fix;
      s2_in.xu   = s1_ff.x * s1_ff.u;
      s2_in.yv   = s1_ff.y * s1_ff.v;
      s2_in.xv   = s1_ff.x * s1_ff.v;
      s2_in.yu   = s1_ff.y * s1_ff.u;
      s2_in.uu   = s1_ff.u * s1_ff.u;
      s2_in.vv   = s1_ff.v * s1_ff.v;
   end

   // stage 3: cross sums and |divisor|^2
   always_comb begin
      s3_in.kind = s2_ff.kind;
      s3_in.fix  = s2_ff.fix;
      if (s2_ff.kind == KIND_MUL) begin
         s3_in.p = sxp(s2_ff.xu) - sxp(s2_ff.yv);
         s3_in.q = sxp(s2_ff.xv) + sxp(s2_ff.yu);
      end else begin
         s3_in.p = sxp(s2_ff.xu) + sxp(s2_ff.yv);
         s3_in.q = sxp(s2_ff.yu) - sxp(s2_ff.xv);
      end
      s3_in.den = PROD_BITS'($unsigned(s2_ff.uu)) + PROD_BITS'($unsigned(s2_ff.vv));
   end

   // stage 4: product rescale, divide and root setup
   always_comb begin
      mul_re = sat_sum(s3_ff.p >>> FRAC_BITS);
      mul_im = sat_sum(s3_ff.q >>> FRAC_BITS);
      s4_in.kind = s3_ff.kind;
      if (s3_ff.kind == KIND_MUL) begin
         s4_in.fix.re  = mul_re.value;
         s4_in.fix.im  = mul_im.value;
         s4_in.fix.cmp = 1'b0;
         s4_in.fix.sat = mul_re.sat | mul_im.sat;
      end else begin
         s4_in.fix = s3_ff.fix;
      end
      s4_in.dz      = (s3_ff.den == '0);
      s4_in.den     = s3_ff.den;
      s4_in.lane_r  = lane_init(s3_ff.p, s3_ff.den);
      s4_in.lane_i  = lane_init(s3_ff.q, s3_ff.den);
      s4_in.sq_x    = s3_ff.den;
      s4_in.sq_rem  = '0;
      s4_in.sq_root = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s1_ff <= s1_in;
         s2_ff <= s2_in;
         s3_ff <= s3_in;
         s4_ff <= s4_in;
      end
   end

   assign out_valid = v4_ff;
   assign out_data  = s4_ff;

endmodule

@@ rtl/core/cau_iter_stage.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_iter_stage
// One quotient bit per divide lane and one root bit, registered.
// ----------------------------------------------------------------------------
module cau_iter_stage (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  cau_pkg::iter_type in_data,
   output logic              out_valid,
   output cau_pkg::iter_type out_data
);
   import cau_pkg::*;

   iter_type                step_in, step_ff;
   logic                    valid_ff;
   logic [SQREM_BITS+1:0]   sq_t;
   logic [SQREM_BITS+1:0]   sq_trial;

   // restoring divide step
   function automatic div_lane_type div_step(input div_lane_type l,
                                             input logic [PROD_BITS-1:0] den);
      logic [PROD_BITS:0] rd;
      div_lane_type       r;
      rd = {l.rem, l.num[WORD_BITS-1]};
      r  = l;
      if (rd >= {1'b0, den}) begin
         r.rem = PROD_BITS'(rd - {1'b0, den});
         r.q   = {l.q[WORD_BITS-2:0], 1'b1};
      end else begin
         r.rem = rd[PROD_BITS-1:0];
         r.q   = {l.q[WORD_BITS-2:0], 1'b0};
      end
      r.num = l.num << 1;
      return r;
   endfunction

   always_comb begin
      step_in        = in_data;
      step_in.lane_r = div_step(in_data.lane_r, in_data.den);
      step_in.lane_i = div_step(in_data.lane_i, in_data.den);
      // digit-by-digit square root, two radicand bits per step
      sq_t     = {in_data.sq_rem, in_data.sq_x[PROD_BITS-1 -: 2]};
      sq_trial = {2'b00, in_data.sq_root, 2'b01};
      if (sq_t >= sq_trial) begin
         step_in.sq_rem  = SQREM_BITS'(sq_t - sq_trial);
         step_in.sq_root = {in_data.sq_root[WORD_BITS-2:0], 1'b1};
      end else begin
         step_in.sq_rem  = SQREM_BITS'(sq_t);
         step_in.sq_root = {in_data.sq_root[WORD_BITS-2:0], 1'b0};
      end
      step_in.sq_x = in_data.sq_x << 2;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         step_ff <= step_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = step_ff;

endmodule

@@ rtl/core/cau_finish.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cau_finish
// Quotient sign and clamp, root clamp, result select and status.
// ----------------------------------------------------------------------------
module cau_finish (
   input  cau_pkg::iter_type in_data,
   output cau_pkg::rsp_type  out_data
);
   import cau_pkg::*;

   sat_type  fr, fi;
   word_type re, im;
   logic     sat, dz, cmp;

   function automatic sat_type fin_lane(input div_lane_type l);
      sat_type r;
      if (l.ovf) begin
         r.sat   = 1'b1;
         r.value = l.neg ? WORD_MIN : WORD_MAX;
      end else if (l.neg) begin
         if (l.q > WORD_HALF) begin
            r.sat   = 1'b1;
            r.value = WORD_MIN;
         end else begin
            r.sat   = 1'b0;
            r.value = word_type'(~l.q + 1'b1);
         end
      end else if (l.q[WORD_BITS-1]) begin
         r.sat   = 1'b1;
         r.value = WORD_MAX;
      end else begin
         r.sat   = 1'b0;
         r.value = l.q;
      end
      return r;
   endfunction

   always_comb begin
      fr  = fin_lane(in_data.lane_r);
      fi  = fin_lane(in_data.lane_i);
      dz  = 1'b0;
      cmp = 1'b0;
      case (in_data.kind)
         KIND_DIV, KIND_INV: begin
            dz  = in_data.dz;
            re  = in_data.dz ? '0 : fr.value;
            im  = in_data.dz ? '0 : fi.value;
            sat = !in_data.dz && (fr.sat || fi.sat);
         end
         KIND_MAG: begin
            im = '0;
            if (in_data.sq_root[WORD_BITS-1]) begin
               re  = WORD_MAX;
               sat = 1'b1;
            end else begin
               re  = in_data.sq_root;
               sat = 1'b0;
            end
         end
         default: begin
            re  = in_data.fix.re;
            im  = in_data.fix.im;
            cmp = in_data.fix.cmp;
            sat = in_data.fix.sat;
         end
      endcase
      out_data.result_real  = FIELD_BITS'(re);
      out_data.result_imag  = FIELD_BITS'(im);
      out_data.compare_true = cmp;
      out_data.status       = dz ? STATUS_DIV_ZERO : (sat ? STATUS_SATURATED : STATUS_OK);
   end

endmodule

@@ rtl/core/complex_arithmetic_unit_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core
// Pipelined complex ALU on signed Q16.16: add, sub, mul, div, negate,
// conjugate, inverse, compares and magnitude.
// ----------------------------------------------------------------------------
//
//   channel   handshake              beat
//   req_      req_valid/req_ready    req_data (kind, operand A, operand B)
//   rsp_      rsp_valid/rsp_ready    rsp_data (result, compare_true, status)
//
// One beat per cycle sustained unless the output buffer fills; every op takes
// the same path from accept to rsp_valid: four front stages, one stage per
// quotient/root bit (32), output reg; the bit-serial divide/root lanes dominate.
// Reset (sync, active high) clears only the valid bits, including the output buffer's.
// Stalls freeze the whole pipe; a two-entry output buffer keeps req_ready
// registered and lets one more beat in while a result waits.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  cau_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output cau_pkg::rsp_type rsp_data
);
   import cau_pkg::*;

   `include "complex_arithmetic_unit_core_assert.svh"

   logic                   en;
   logic [ITER_STAGES:0]   chain_valid;
   iter_type               chain_data [0:ITER_STAGES];
   rsp_type                fin_data;
   rsp_type                out_ff, skid_ff;
   logic                   out_v_ff, skid_v_ff;
   logic                   push, pop;

   // pipe advances unless the output buffer is full
   assign en        = !skid_v_ff;
   assign req_ready = en;

   cau_front u_front (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .in_valid  (req_valid),
      .in_data   (req_data),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0])
   );

   // one quotient bit and one root bit per stage, MSB first
   for (genvar g = 0; g < ITER_STAGES; g++) begin : g_iter
      cau_iter_stage u_stage (
         .clock     (clock),
         .reset     (reset),
         .en        (en),
         .in_valid  (chain_valid[g]),
         .in_data   (chain_data[g]),
         .out_valid (chain_valid[g+1]),
         .out_data  (chain_data[g+1])
      );
   end

   cau_finish u_finish (
      .in_data  (chain_data[ITER_STAGES]),
      .out_data (fin_data)
   );

   // output buffer: out_ff drives the port, skid_ff catches a beat
   // arriving while the port is stalled
   assign push = en && chain_valid[ITER_STAGES];
   assign pop  = out_v_ff && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_v_ff  <= 1'b0;
         skid_v_ff <= 1'b0;
      end else if (pop) begin
         if (skid_v_ff) begin
            out_v_ff  <= 1'b1;
            skid_v_ff <= 1'b0;
         end else begin
            out_v_ff <= push;
         end
      end else if (push) begin
         if (out_v_ff) begin
            skid_v_ff <= 1'b1;
         end else begin
            out_v_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_v_ff) begin
         out_ff <= skid_ff;
      end else if (push && (pop || !out_v_ff)) begin
         out_ff <= fin_data;
      end
      if (push && out_v_ff && !pop) begin
         skid_ff <= fin_data;
      end
   end

   assign rsp_valid = out_v_ff;
   assign rsp_data  = out_ff;

   `CAU_ASSERT_NEXT(a_skid_catch, clock, reset, push && out_v_ff && !pop, skid_v_ff, "stalled beat not caught in skid")
   `CAU_ASSERT_HOLDS(a_skid_order, clock, reset, skid_v_ff, out_v_ff, "skid holds a beat with output empty")
   `CAU_ASSERT_HOLDS(a_dz_zero, clock, reset, rsp_valid && rsp_data.status == STATUS_DIV_ZERO, rsp_data.result_real == '0 && rsp_data.result_imag == '0, "divide by zero with nonzero result")
   `CAU_ASSERT_HOLDS(a_cmp_clean, clock, reset, rsp_valid && rsp_data.compare_true, rsp_data.status == STATUS_OK && rsp_data.result_real == '0 && rsp_data.result_imag == '0, "compare beat carries result or status")

endmodule

@@ verif/complex_arithmetic_unit_core_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// complex_arithmetic_unit_core_test
// Drives directed and random complex operations through the ALU with random
// gaps and stalls on both channels, one long output hold-off, and checks
// every result beat against a local predictor in order.
// ----------------------------------------------------------------------------
module complex_arithmetic_unit_core_test;
   import cau_pkg::*;

   localparam int LATENCY     = 37;
   localparam int CYCLE_LIMIT = 400000;
   localparam int RANDOM_BEATS = 1950;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_ready;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_ready;
   rsp_type rsp_data;

   req_type pending_ops[$];
   rsp_type expected_results[$];
   int      error_count;
   int      cycle_count;
   int      sent_count;
   int      checked_count;
   int      total_ops;
   int      dz_count;
   int      sat_count;
   bit      stim_done;
   bit      hold_off;

   complex_arithmetic_unit_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------------
   // Predictor: wide signed arithmetic, then clamp to the word range.
   // ---------------------------------------------------------------------
   function automatic word_type clamp_word(input logic signed [191:0] v,
                                           inout bit sat);
      if (v > 192'sd2147483647) begin
         sat = 1'b1;
         return WORD_MAX;
      end
      if (v < -192'sd2147483648) begin
         sat = 1'b1;
         return WORD_MIN;
      end
      return word_type'(v);
   endfunction

   // quotient truncated toward zero (SV signed divide truncates)
   function automatic word_type quotient_word(input logic signed [191:0] num,
                                              input logic signed [191:0] den,
                                              inout bit sat);
      logic signed [191:0] q;
      q = num / den;
      return clamp_word(q, sat);
   endfunction

   function automatic rsp_type predict_result(input req_type op);
      logic signed [191:0] a, b, c, d, den, nr, ni, sq;
      logic [127:0] root, acc;
      word_type re, im;
      bit sat, cmp, dz;
      rsp_type r;
      a = 192'(op.a_real); b = 192'(op.a_imag);
      c = 192'(op.b_real); d = 192'(op.b_imag);
      re = '0; im = '0; sat = 1'b0; cmp = 1'b0; dz = 1'b0;
      case (op.kind)
         KIND_ADD: begin
            re = clamp_word(a + c, sat);
            im = clamp_word(b + d, sat);
         end
         KIND_SUB: begin
            re = clamp_word(a - c, sat);
            im = clamp_word(b - d, sat);
         end
         KIND_MUL: begin
            re = clamp_word((a * c - b * d) >>> FRAC_BITS, sat);
            im = clamp_word((a * d + b * c) >>> FRAC_BITS, sat);
         end
         KIND_DIV, KIND_INV: begin
            if (op.kind == KIND_INV) begin
               c = a; d = b; a = 192'sd1 <<< FRAC_BITS; b = '0;
            end
            den = c * c + d * d;
            if (den == 0) dz = 1'b1;
            else begin
               nr = (a * c + b * d) <<< FRAC_BITS;
               ni = (b * c - a * d) <<< FRAC_BITS;
               re = quotient_word(nr, den, sat);
               im = quotient_word(ni, den, sat);
            end
         end
         KIND_NEG: begin
            re = clamp_word(-a, sat);
            im = clamp_word(-b, sat);
         end
         KIND_CONJ: begin
            re = word_type'(a);
            im = clamp_word(-b, sat);
         end
         KIND_EQ: cmp = (a == c) && (b == d);
         KIND_LT: cmp = (a < c) && (b < d);
         KIND_GT: cmp = (a > c) && (b > d);
         KIND_MAG: begin
            sq = a * a + b * b;
            acc = sq[127:0];
            root = '0;
            // bitwise floor sqrt
            for (int i = 63; i >= 0; i--) begin
               if ((root | (128'd1 << i)) * (root | (128'd1 << i)) <= acc)
                  root = root | (128'd1 << i);
            end
            if (root > 128'd2147483647) begin
               sat = 1'b1;
               re = WORD_MAX;
            end else re = word_type'(root);
         end
         default: ;
      endcase
      r.result_real  = re;
      r.result_imag  = im;
      r.compare_true = cmp;
      r.status       = dz ? STATUS_DIV_ZERO : (sat ? STATUS_SATURATED : STATUS_OK);
      return r;
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(9))
         0: return WORD_MIN;
         1: return WORD_MAX;
         2: return '0;
         3: return word_type'($urandom_range(2)) - 1;
         4, 5: return word_type'($signed($urandom) >>> $urandom_range(31));
         6: return FIX_ONE * ($signed($urandom_range(64)) - 32);
         default: return word_type'($urandom);
      endcase
   endfunction

   task automatic queue_op(input logic [3:0] kind, input word_type ar,
                           input word_type ai, input word_type br,
                           input word_type bi);
      req_type op;
      op.kind = kind; op.a_real = ar; op.a_imag = ai;
      op.b_real = br; op.b_imag = bi;
      pending_ops.push_back(op);
   endtask

   // ---------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------
   initial begin
      word_type x, y;
      logic [3:0] k;
      reset = 1'b1;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // directed: each op, extremes, zero divisor, most negative negate
      queue_op(KIND_ADD, WORD_MAX, WORD_MIN, 32'sd1, -32'sd1);
      queue_op(KIND_SUB, WORD_MIN, WORD_MAX, 32'sd1, -32'sd1);
      queue_op(KIND_MUL, WORD_MAX, WORD_MAX, WORD_MIN, WORD_MAX);
      queue_op(KIND_MUL, FIX_ONE, FIX_ONE, -FIX_ONE, FIX_ONE);
      queue_op(KIND_DIV, FIX_ONE, 0, 0, 0);
      queue_op(KIND_DIV, WORD_MAX, WORD_MIN, 32'sd1, 0);
      queue_op(KIND_DIV, -FIX_ONE * 3, FIX_ONE, FIX_ONE, -FIX_ONE * 2);
      queue_op(KIND_NEG, WORD_MIN, WORD_MAX, 0, 0);
      queue_op(KIND_CONJ, WORD_MAX, WORD_MIN, 0, 0);
      queue_op(KIND_INV, 0, 0, 0, 0);
      queue_op(KIND_INV, 32'sd1, 0, 0, 0);
      queue_op(KIND_INV, -FIX_ONE * 2, FIX_ONE, 0, 0);
      queue_op(KIND_EQ, 32'sd5, -32'sd5, 32'sd5, -32'sd5);
      queue_op(KIND_EQ, 32'sd5, -32'sd5, 32'sd5, -32'sd4);
      queue_op(KIND_LT, WORD_MIN, 0, WORD_MAX, 1);
      queue_op(KIND_LT, WORD_MIN, 1, WORD_MAX, 1);
      queue_op(KIND_GT, WORD_MAX, 1, WORD_MIN, 0);
      queue_op(KIND_GT, WORD_MAX, 0, WORD_MIN, 0);
      queue_op(KIND_MAG, WORD_MIN, WORD_MIN, 0, 0);
      queue_op(KIND_MAG, FIX_ONE * 3, -FIX_ONE * 4, 0, 0);
      queue_op(4'd11, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
      queue_op(4'd15, -32'sd1, -32'sd1, -32'sd1, -32'sd1);

      for (int n = 0; n < RANDOM_BEATS; n++) begin
         k = ($urandom_range(19) == 0) ? 4'($urandom_range(15, 11))
                                       : 4'($urandom_range(10));
         x = pick_operand();
         y = pick_operand();
         // compares get equal components now and then
         if (k >= KIND_EQ && k <= KIND_GT && $urandom_range(2) == 0)
            queue_op(k, x, y, x, ($urandom_range(1)) ? y : pick_operand());
         else
            queue_op(k, x, y, pick_operand(), pick_operand());
      end
      total_ops = pending_ops.size();
      stim_done = 1'b1;
   end

   // ---------------------------------------------------------------------
   // Driver: pops queued ops, random gaps, valid held until accepted
   // ---------------------------------------------------------------------
   int send_gap;
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap  <= 0;
      end else if (!req_valid || req_ready) begin
         // current beat (if any) is accepted this edge
         if (req_valid) begin
            expected_results.push_back(predict_result(req_data));
            sent_count <= sent_count + 1;
         end
         if (send_gap > 0) begin
            send_gap  <= send_gap - 1;
            req_valid <= 1'b0;
         end else if (pending_ops.size() > 0) begin
            req_data  <= pending_ops.pop_front();
            req_valid <= 1'b1;
            send_gap  <= ($urandom_range(9) < 6) ? 0 :
                         ($urandom_range(19) == 0) ? $urandom_range(40, 10)
                                                   : $urandom_range(3);
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // ---------------------------------------------------------------------
   // Monitor: random stalls, one long hold-off, in-order compare
   // ---------------------------------------------------------------------
   int stall_left;
   always @(posedge clock) begin
      rsp_type want;
      if (reset) begin
         rsp_ready  <= 1'b0;
         stall_left <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            checked_count <= checked_count + 1;
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, rsp_data);
               error_count <= error_count + 1;
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.status == STATUS_DIV_ZERO) dz_count <= dz_count + 1;
               if (rsp_data.status == STATUS_SATURATED) sat_count <= sat_count + 1;
               if (rsp_data.result_real !== want.result_real ||
                   rsp_data.result_imag !== want.result_imag ||
                   rsp_data.compare_true !== want.compare_true ||
                   rsp_data.status !== want.status) begin
                  $display("%0t: mismatch expected re=%h im=%h cmp=%b st=%0d",
                           $time, want.result_real, want.result_imag,
                           want.compare_true, want.status);
                  $display("%0t:            actual re=%h im=%h cmp=%b st=%0d",
                           $time, rsp_data.result_real, rsp_data.result_imag,
                           rsp_data.compare_true, rsp_data.status);
                  error_count <= error_count + 1;
               end
            end
         end
         // long hold-off once, mid run, so the pipe backs up into req_ready
         if (!hold_off && sent_count >= 400) begin
            hold_off   <= 1'b1;
            stall_left <= 300;
            rsp_ready  <= 1'b0;
         end else if (stall_left > 0) begin
            stall_left <= stall_left - 1;
            rsp_ready  <= 1'b0;
         end else if (sent_count > 1200 && sent_count < 1500) begin
            rsp_ready <= 1'b1;
         end else if ($urandom_range(9) < 2) begin
            rsp_ready  <= 1'b0;
            stall_left <= ($urandom_range(14) == 0) ? $urandom_range(60, 10)
                                                    : $urandom_range(2);
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // ---------------------------------------------------------------------
   // End of run and watchdog
   // ---------------------------------------------------------------------
   initial begin
      req_valid = 1'b0; rsp_ready = 1'b0; req_data = '0;
      error_count = 0; cycle_count = 0; sent_count = 0; checked_count = 0;
      dz_count = 0; sat_count = 0; stim_done = 0; hold_off = 0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results outstanding", $time,
                  expected_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      wait (stim_done);
      // every queued op sent and every result beat taken
      wait (sent_count == total_ops && checked_count == total_ops);
      repeat (2 * LATENCY) @(posedge clock);
      $display("Ran %0d ops through all kinds incl. unused codes; %0d results checked,",
               sent_count, checked_count);
      $display("%0d divide-by-zero and %0d saturated, with random and long stalls.",
               dz_count, sat_count);
      if (error_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
